// ----- rtl/core/pas_pkg.sv -----
// Shared types, constants and helpers for the particle attractor step unit.
package pas_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 12;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int ROOT_W    = DIFF_W;
  localparam int DIV_W     = 8;
  localparam int DEN_W     = ROOT_W + DIV_W;
  localparam int NUM_W     = DIFF_W + FRAC_BITS;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int SUM_W     = COORD_W + 2;
  localparam int GRAVITY_Q = ((5 << FRAC_BITS) + 50) / 100;
  localparam int FLOOR_Q   = 199 << FRAC_BITS;
  localparam int PULL_DIV_RESET = 20;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    REG_ATTR_X = 2'd0,
    REG_ATTR_Y = 2'd1,
    REG_PULL_DIV = 2'd2,
    REG_REPEL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t vel_x;
    coord_t vel_y;
  } in_t;

  typedef struct packed {
    coord_t new_pos_x;
    coord_t new_pos_y;
    coord_t new_vel_x;
    coord_t new_vel_y;
    logic   bounced;
    logic   saturated;
  } out_t;

  // Particle data carried alongside the arithmetic cells
  typedef struct packed {
    coord_t              px;
    coord_t              py;
    coord_t              vx;
    coord_t              vy;
    logic [DIFF_W-1:0]   mag_x;
    logic [DIFF_W-1:0]   mag_y;
    logic                neg_x;
    logic                neg_y;
    logic                nz;
    logic                act;
  } part_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] rem_x;
    logic [NUM_W-1:0] rem_y;
    logic [Q_W-1:0]   q_x;
    logic [Q_W-1:0]   q_y;
  } dv_t;

  function automatic coord_t sat_c(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 1);
    lo = -SUM_W'(64'sd1 <<< (COORD_W - 1));
    if (v > hi) return coord_t'(hi);
    else if (v < lo) return coord_t'(lo);
    else return coord_t'(v);
  endfunction

  function automatic logic ovf_c(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 1);
    lo = -SUM_W'(64'sd1 <<< (COORD_W - 1));
    return (v > hi) || (v < lo);
  endfunction

endpackage

// ----- rtl/core/pas_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cycle.
module pas_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  pas_pkg::part_t in_part,
  input  pas_pkg::sq_t   in_sq,
  output logic           out_valid,
  output pas_pkg::part_t out_part,
  output pas_pkg::sq_t   out_sq
);
  import pas_pkg::*;

  logic [SQ_W:0] trial;
  logic          take;
  sq_t           sq_next;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  always_comb begin
    trial = ({{(SQ_W + 1 - ROOT_W){1'b0}}, in_sq.root} << (BIT + 1))
            + ((SQ_W + 1)'(1) << (2 * BIT));
    take  = {1'b0, in_sq.rem} >= trial;
    sq_next = in_sq;
    if (take) begin
      sq_next.rem  = SQ_W'({1'b0, in_sq.rem} - trial);
      sq_next.root = in_sq.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_part <= in_part;
    out_sq   <= sq_next;
  end

endmodule

// ----- rtl/core/pas_div_cell.sv -----
// One cell of the pull divider chain: settles one quotient bit per lane per cycle.
module pas_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  pas_pkg::part_t in_part,
  input  pas_pkg::dv_t   in_dv,
  output logic           out_valid,
  output pas_pkg::part_t out_part,
  output pas_pkg::dv_t   out_dv
);
  import pas_pkg::*;

  localparam int CMP_W = DEN_W + Q_W;

  logic [CMP_W-1:0] term;
  logic [CMP_W-1:0] rx;
  logic [CMP_W-1:0] ry;
  dv_t              dv_next;

  always_comb begin
    term = {{Q_W{1'b0}}, in_dv.den} << BIT;
    rx   = {{(CMP_W - NUM_W){1'b0}}, in_dv.rem_x};
    ry   = {{(CMP_W - NUM_W){1'b0}}, in_dv.rem_y};
    dv_next = in_dv;
    if (rx >= term) begin
      dv_next.rem_x = NUM_W'(rx - term);
      dv_next.q_x   = in_dv.q_x | (Q_W'(1) << BIT);
    end
    if (ry >= term) begin
      dv_next.rem_y = NUM_W'(ry - term);
      dv_next.q_y   = in_dv.q_y | (Q_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_part <= in_part;
    out_dv   <= dv_next;
  end

endmodule

// ----- rtl/core/particle_attractor_step_unit.sv -----
// Top level of the particle attractor step unit: pipeline of arithmetic cells.
//
// Use: raise start with a particle word on particle_in; it is taken at any
// clock edge where start is high and busy is low. busy stays low, so one
// particle can be taken every cycle. Each particle yields one result word on
// particle_out, marked by done for exactly one cycle, after it has passed every
// stage of the pipeline. Results leave in the order particles came in.
// The depth is set by the 25-cell square root chain (one root bit per cell)
// and the 13-cell divider chain (one quotient bit per cell), plus three
// front stages, one scaling multiply and two output stages.
// Configuration: write cfg_data to register cfg_index while cfg_valid is
// high; cfg_ready is always high. Write only while no particle is in flight.
// Reset (rst, synchronous) empties the pipeline and restores the attractor
// to the origin, the pull divisor to 20 and attract mode.
// The receiver cannot stall: done is a plain strobe and must be sampled.
module particle_attractor_step_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pas_pkg::in_t  particle_in,
  output logic          done,
  output pas_pkg::out_t particle_out,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [23:0]   cfg_data
);
  import pas_pkg::*;

  coord_t           attr_x;
  coord_t           attr_y;
  logic [DIV_W-1:0] pull_div;
  logic             repel;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr_x   <= '0;
      attr_y   <= '0;
      pull_div <= DIV_W'(PULL_DIV_RESET);
      repel    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ATTR_X:   attr_x   <= coord_t'(cfg_data);
        REG_ATTR_Y:   attr_y   <= coord_t'(cfg_data);
        REG_PULL_DIV: pull_div <= cfg_data[DIV_W-1:0];
        REG_REPEL:    repel    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: offsets to the attractor and their magnitudes
  logic                      v1;
  part_t                     p1;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;

  always_comb begin
    dx = DIFF_W'(attr_x) - DIFF_W'(particle_in.pos_x);
    dy = DIFF_W'(attr_y) - DIFF_W'(particle_in.pos_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    p1.px    <= particle_in.pos_x;
    p1.py    <= particle_in.pos_y;
    p1.vx    <= particle_in.vel_x;
    p1.vy    <= particle_in.vel_y;
    p1.neg_x <= dx[DIFF_W-1];
    p1.neg_y <= dy[DIFF_W-1];
    p1.mag_x <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    p1.mag_y <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    p1.nz    <= (dx != '0) || (dy != '0);
    p1.act   <= 1'b0;
  end

  // Stage 2: squares
  logic            v2;
  part_t           p2;
  logic [SQ_W-1:0] sqx;
  logic [SQ_W-1:0] sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p2  <= p1;
    sqx <= SQ_W'(p1.mag_x) * SQ_W'(p1.mag_x);
    sqy <= SQ_W'(p1.mag_y) * SQ_W'(p1.mag_y);
  end

  // Stage 3: sum of squares seeds the root chain
  logic  sv [ROOT_W+1];
  part_t sp [ROOT_W+1];
  sq_t   ss [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sp[0]      <= p2;
    ss[0].rem  <= sqx + sqy;
    ss[0].root <= '0;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    pas_sqrt_cell #(.BIT(ROOT_W - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sv[i]),
      .in_part  (sp[i]),
      .in_sq    (ss[i]),
      .out_valid(sv[i+1]),
      .out_part (sp[i+1]),
      .out_sq   (ss[i+1])
    );
  end

  // Scale the length by the divisor and seed the divider chain
  logic  dvv [Q_W+1];
  part_t dvp [Q_W+1];
  dv_t   dvd [Q_W+1];
  part_t dvp_next;

  always_comb begin
    dvp_next     = sp[ROOT_W];
    dvp_next.act = sp[ROOT_W].nz && (pull_div != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else begin
      dvv[0] <= sv[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    dvp[0]       <= dvp_next;
    dvd[0].den   <= DEN_W'(ss[ROOT_W].root) * DEN_W'(pull_div);
    dvd[0].rem_x <= {sp[ROOT_W].mag_x, {FRAC_BITS{1'b0}}};
    dvd[0].rem_y <= {sp[ROOT_W].mag_y, {FRAC_BITS{1'b0}}};
    dvd[0].q_x   <= '0;
    dvd[0].q_y   <= '0;
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    pas_div_cell #(.BIT(Q_W - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dvv[i]),
      .in_part  (dvp[i]),
      .in_dv    (dvd[i]),
      .out_valid(dvv[i+1]),
      .out_part (dvp[i+1]),
      .out_dv   (dvd[i+1])
    );
  end

  // Velocity update by the pull (or push, in repel mode)
  logic                   vf;
  part_t                  pf;
  part_t                  pf_next;
  logic                   satf;
  logic signed [SUM_W-1:0] fx;
  logic signed [SUM_W-1:0] fy;
  logic signed [SUM_W-1:0] nvx;
  logic signed [SUM_W-1:0] nvy;

  always_comb begin
    part_t pq;
    pq = dvp[Q_W];
    fx = SUM_W'(signed'({1'b0, dvd[Q_W].q_x}));
    fy = SUM_W'(signed'({1'b0, dvd[Q_W].q_y}));
    if (pq.neg_x) fx = -fx;
    if (pq.neg_y) fy = -fy;
    if (!pq.act) begin
      fx = '0;
      fy = '0;
    end
    if (repel) begin
      nvx = SUM_W'(pq.vx) - fx;
      nvy = SUM_W'(pq.vy) - fy;
    end else begin
      nvx = SUM_W'(pq.vx) + fx;
      nvy = SUM_W'(pq.vy) + fy;
    end
    pf_next    = pq;
    pf_next.vx = sat_c(nvx);
    pf_next.vy = sat_c(nvy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else begin
      vf <= dvv[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    pf   <= pf_next;
    satf <= ovf_c(nvx) || ovf_c(nvy);
  end

  // Move, add gravity, bounce off the floor
  logic signed [SUM_W-1:0] spx;
  logic signed [SUM_W-1:0] spy;
  logic signed [SUM_W-1:0] svy;
  coord_t                  py_s;
  coord_t                  vy_s;
  coord_t                  half;
  logic                    hit;
  out_t                    res_next;

  always_comb begin
    spx  = SUM_W'(pf.px) + SUM_W'(pf.vx);
    spy  = SUM_W'(pf.py) + SUM_W'(pf.vy);
    svy  = SUM_W'(pf.vy) + SUM_W'(GRAVITY_Q);
    py_s = sat_c(spy);
    vy_s = sat_c(svy);
    // halve toward zero
    half = (vy_s + coord_t'(vy_s[COORD_W-1])) >>> 1;
    hit  = SUM_W'(py_s) > SUM_W'(FLOOR_Q);
    res_next.new_pos_x = sat_c(spx);
    res_next.new_pos_y = hit ? coord_t'(FLOOR_Q) : py_s;
    res_next.new_vel_x = pf.vx;
    res_next.new_vel_y = hit ? -half : vy_s;
    res_next.bounced   = hit;
    res_next.saturated = satf || ovf_c(spx) || ovf_c(spy) || ovf_c(svy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vf;
    end
  end

  always_ff @(posedge clk) begin
    particle_out <= res_next;
  end

endmodule
